// File: hw/rtl/ipv4_l4_header_extractor_unit_macros.svh
// ----------------------------------------------------------------------------
// IPv4 L4 header extractor assertion macros
// Shared concurrent assertion forms used by the extractor RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_L4_HEADER_EXTRACTOR_UNIT_MACROS_SVH
`define IPV4_L4_HEADER_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define L4HX_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("l4hx: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define L4HX_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("l4hx: next-cycle check failed");

`endif

// File: hw/rtl/l4hx_pkg.sv
// ----------------------------------------------------------------------------
// l4hx_pkg
// Types, offsets and codes shared by the IPv4 L4 header extractor.
// ----------------------------------------------------------------------------
package l4hx_pkg;

    // Byte position counter width (saturating)
    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Link type codes
    localparam logic [1:0] LINK_ETHERNET = 2'd0;
    localparam logic [1:0] LINK_COOKED   = 2'd1;
    localparam logic [1:0] LINK_LOOPBACK = 2'd2;
    localparam logic [1:0] LINK_NONE     = 2'd3;

    // Link header lengths in bytes
    localparam logic [POS_W-1:0] ETH_HDR_LEN    = POS_W'(14);
    localparam logic [POS_W-1:0] COOKED_HDR_LEN = POS_W'(16);
    localparam logic [POS_W-1:0] LOOP_HDR_LEN   = POS_W'(4);

    // EtherType location in an Ethernet header
    localparam logic [POS_W-1:0] ETYPE_FIRST = POS_W'(12);
    localparam logic [POS_W-1:0] ETYPE_LAST  = POS_W'(13);

    // Offsets from the start of the IPv4 header
    localparam logic [POS_W-1:0] IP_LEN_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] IP_LEN_LAST  = POS_W'(3);
    localparam logic [POS_W-1:0] IP_TTL       = POS_W'(8);
    localparam logic [POS_W-1:0] IP_PROTO     = POS_W'(9);
    localparam logic [POS_W-1:0] IP_SRC_FIRST = POS_W'(12);
    localparam logic [POS_W-1:0] IP_SRC_LAST  = POS_W'(15);
    localparam logic [POS_W-1:0] IP_DST_FIRST = POS_W'(16);
    localparam logic [POS_W-1:0] IP_DST_LAST  = POS_W'(19);

    // Offsets from the start of the transport header
    localparam logic [POS_W-1:0] L4_PORT_FIRST = POS_W'(0);
    localparam logic [POS_W-1:0] L4_PORT_LAST  = POS_W'(3);
    localparam logic [POS_W-1:0] L4_SEQ_FIRST  = POS_W'(4);
    localparam logic [POS_W-1:0] L4_SEQ_LAST   = POS_W'(7);
    localparam logic [POS_W-1:0] L4_ACK_FIRST  = POS_W'(8);
    localparam logic [POS_W-1:0] L4_ACK_LAST   = POS_W'(11);
    localparam logic [POS_W-1:0] L4_FLAGS      = POS_W'(13);
    localparam logic [POS_W-1:0] L4_WIN_FIRST  = POS_W'(14);
    localparam logic [POS_W-1:0] L4_WIN_LAST   = POS_W'(15);

    // Protocol constants
    localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  IHL_MIN         = 4'd5;

    // Result status codes
    localparam logic [1:0] STATUS_NOT_IP  = 2'd0;
    localparam logic [1:0] STATUS_IPV4    = 2'd1;
    localparam logic [1:0] STATUS_BAD_IHL = 2'd2;

    // Config register map
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_LINK_TYPE = '0;

    // Header fields captured while a frame passes
    typedef struct packed {
        logic [15:0] ether_kind;
        logic [3:0]  header_words;
        logic [7:0]  proto;
        logic [7:0]  ttl;
        logic [15:0] length;
        logic [31:0] source;
        logic [31:0] dest;
        logic [31:0] ports;
        logic [5:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] window;
    } frame_fields_t;

    // One result request
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  protocol;
        logic [7:0]  ttl;
        logic [15:0] ip_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [5:0]  tcp_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] window;
    } result_t;

    // Link header length for a link type
    function automatic logic [POS_W-1:0] link_len(input logic [1:0] link_type);
        logic [POS_W-1:0] len;
        case (link_type)
            LINK_ETHERNET: len = ETH_HDR_LEN;
            LINK_COOKED:   len = COOKED_HDR_LEN;
            default:       len = LOOP_HDR_LEN;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/l4hx_capture.sv
// ----------------------------------------------------------------------------
// l4hx_capture
// Byte position counter and header field registers; captures each field
// as its bytes pass and clears after the last byte of a frame.
// ----------------------------------------------------------------------------
`include "ipv4_l4_header_extractor_unit_macros.svh"

module l4hx_capture (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [1:0]                    link_type,
    output l4hx_pkg::frame_fields_t       fields_next
);

    logic [l4hx_pkg::POS_W-1:0] position_reg;
    logic [l4hx_pkg::POS_W-1:0] position_next;
    l4hx_pkg::frame_fields_t    fields_reg;

    logic [l4hx_pkg::POS_W-1:0] ip_start;
    logic [l4hx_pkg::POS_W-1:0] l4_start;
    logic [l4hx_pkg::POS_W-1:0] ip_rel;
    logic [l4hx_pkg::POS_W-1:0] l4_rel;
    logic                       in_ip;
    logic                       in_l4;

    // Locate the current byte relative to the IP and transport headers
    always_comb
    begin
        ip_start = l4hx_pkg::link_len(link_type);
        l4_start = ip_start + l4hx_pkg::POS_W'({fields_reg.header_words, 2'b00});
        ip_rel   = position_reg - ip_start;
        l4_rel   = position_reg - l4_start;
        in_ip    = (position_reg >= ip_start);
        in_l4    = (position_reg >= l4_start) && (position_reg > ip_start)
                   && (fields_reg.header_words >= l4hx_pkg::IHL_MIN);
    end

    // Shift each byte into the field it belongs to
    always_comb
    begin
        fields_next = fields_reg;
        if (position_reg inside {[l4hx_pkg::ETYPE_FIRST:l4hx_pkg::ETYPE_LAST]})
        begin
            fields_next.ether_kind = {fields_reg.ether_kind[7:0], data_byte};
        end
        if (in_ip)
        begin
            if (ip_rel == '0)
            begin
                fields_next.header_words = data_byte[3:0];
            end
            if (ip_rel inside {[l4hx_pkg::IP_LEN_FIRST:l4hx_pkg::IP_LEN_LAST]})
            begin
                fields_next.length = {fields_reg.length[7:0], data_byte};
            end
            if (ip_rel == l4hx_pkg::IP_TTL)
            begin
                fields_next.ttl = data_byte;
            end
            if (ip_rel == l4hx_pkg::IP_PROTO)
            begin
                fields_next.proto = data_byte;
            end
            if (ip_rel inside {[l4hx_pkg::IP_SRC_FIRST:l4hx_pkg::IP_SRC_LAST]})
            begin
                fields_next.source = {fields_reg.source[23:0], data_byte};
            end
            if (ip_rel inside {[l4hx_pkg::IP_DST_FIRST:l4hx_pkg::IP_DST_LAST]})
            begin
                fields_next.dest = {fields_reg.dest[23:0], data_byte};
            end
        end
        if (in_l4)
        begin
            if (l4_rel inside {[l4hx_pkg::L4_PORT_FIRST:l4hx_pkg::L4_PORT_LAST]})
            begin
                fields_next.ports = {fields_reg.ports[23:0], data_byte};
            end
            if (l4_rel inside {[l4hx_pkg::L4_SEQ_FIRST:l4hx_pkg::L4_SEQ_LAST]})
            begin
                fields_next.seq = {fields_reg.seq[23:0], data_byte};
            end
            if (l4_rel inside {[l4hx_pkg::L4_ACK_FIRST:l4hx_pkg::L4_ACK_LAST]})
            begin
                fields_next.ack = {fields_reg.ack[23:0], data_byte};
            end
            if (l4_rel == l4hx_pkg::L4_FLAGS)
            begin
                fields_next.flags = data_byte[5:0];
            end
            if (l4_rel inside {[l4hx_pkg::L4_WIN_FIRST:l4hx_pkg::L4_WIN_LAST]})
            begin
                fields_next.window = {fields_reg.window[7:0], data_byte};
            end
        end
    end

    // Advance the position, saturating at the top
    always_comb
    begin
        if (position_reg != l4hx_pkg::POS_MAX)
        begin
            position_next = position_reg + 1'b1;
        end
        else
        begin
            position_next = position_reg;
        end
    end

    // Update on each accepted request; drop all frame state after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fields_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                position_reg <= '0;
                fields_reg   <= '0;
            end
            else
            begin
                position_reg <= position_next;
                fields_reg   <= fields_next;
            end
        end
    end

    `L4HX_ASSERT_NXT(a_clear_after_last, clk, rst_n, accept && last_byte, position_reg == '0 && fields_reg == '0)
    `L4HX_ASSERT_NXT(a_hold_when_idle, clk, rst_n, !accept, $stable(position_reg) && $stable(fields_reg))

endmodule

// File: hw/rtl/l4hx_result.sv
// ----------------------------------------------------------------------------
// l4hx_result
// Forms the result from the captured header fields on the last byte and
// holds it in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
`include "ipv4_l4_header_extractor_unit_macros.svh"

module l4hx_result (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [1:0]              link_type,
    input  l4hx_pkg::frame_fields_t fields,
    input  logic                    out_ready,
    output logic                    out_valid,
    output l4hx_pkg::result_t       result
);

    logic              out_valid_reg;
    logic              out_valid_next;
    l4hx_pkg::result_t result_reg;
    l4hx_pkg::result_t result_next;
    logic              ihl_ok;
    logic              is_tcp;
    logic              is_udp;
    logic              shown_not_parsed;
    logic              shown_not_tcp;
    logic              no_l4_fields;
    logic              no_tcp_fields;

    // Build the result; fields that do not apply stay zero
    always_comb
    begin
        result_next = '0;
        ihl_ok      = (fields.header_words >= l4hx_pkg::IHL_MIN);
        is_tcp      = (fields.proto == l4hx_pkg::PROTO_TCP);
        is_udp      = (fields.proto == l4hx_pkg::PROTO_UDP);
        if ((link_type == l4hx_pkg::LINK_ETHERNET)
            && (fields.ether_kind != l4hx_pkg::ETHER_TYPE_IPV4))
        begin
            result_next.status = l4hx_pkg::STATUS_NOT_IP;
        end
        else
        begin
            result_next.status    = ihl_ok ? l4hx_pkg::STATUS_IPV4 : l4hx_pkg::STATUS_BAD_IHL;
            result_next.protocol  = fields.proto;
            result_next.ttl       = fields.ttl;
            result_next.ip_length = fields.length;
            result_next.src_addr  = fields.source;
            result_next.dst_addr  = fields.dest;
            if (ihl_ok && (is_tcp || is_udp))
            begin
                result_next.source_port = fields.ports[31:16];
                result_next.dest_port   = fields.ports[15:0];
            end
            if (ihl_ok && is_tcp)
            begin
                result_next.tcp_flags  = fields.flags;
                result_next.seq_number = fields.seq;
                result_next.ack_number = fields.ack;
                result_next.window     = fields.window;
            end
        end
    end

    // Hold the request until taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Terms for the output checks
    assign shown_not_parsed = out_valid_reg && (result_reg.status != l4hx_pkg::STATUS_IPV4);
    assign shown_not_tcp    = out_valid_reg && (result_reg.protocol != l4hx_pkg::PROTO_TCP);
    assign no_l4_fields     = (result_reg.source_port == '0) && (result_reg.dest_port == '0)
                              && (result_reg.seq_number == '0);
    assign no_tcp_fields    = (result_reg.tcp_flags == '0) && (result_reg.ack_number == '0)
                              && (result_reg.window == '0);

    `L4HX_ASSERT_NXT(a_load_shows, clk, rst_n, load, out_valid_reg)
    `L4HX_ASSERT_IMP(a_l4_only_when_parsed, clk, rst_n, shown_not_parsed, no_l4_fields)
    `L4HX_ASSERT_IMP(a_tcp_fields_only_tcp, clk, rst_n, shown_not_tcp, no_tcp_fields)

endmodule

// File: hw/rtl/ipv4_l4_header_extractor_unit.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_extractor_unit
// Byte-serial IPv4 / TCP / UDP header parser with an APB link type register.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock and returns one header summary per frame,
// registered and shown in the cycle after the byte marked last is accepted.
// in_ready is low only while a finished summary sits in the output register
// and out_ready is low; otherwise a byte is accepted every cycle that in_valid
// is high. The link_type register (byte address 0) selects Ethernet, Linux
// cooked or BSD loopback framing; with link type 3 frames are consumed but no
// summary is produced. Change link_type only between frames.

module ipv4_l4_header_extractor_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [l4hx_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Byte input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    // Header summary output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [7:0]                     protocol,
    output logic [7:0]                     ttl,
    output logic [15:0]                    ip_length,
    output logic [31:0]                    src_addr,
    output logic [31:0]                    dst_addr,
    output logic [15:0]                    source_port,
    output logic [15:0]                    dest_port,
    output logic [5:0]                     tcp_flags,
    output logic [31:0]                    seq_number,
    output logic [31:0]                    ack_number,
    output logic [15:0]                    window
);

    logic [1:0]              link_type_reg;
    logic                    cfg_write;
    logic                    sel_link_type;
    logic                    accept;
    logic                    load;
    l4hx_pkg::frame_fields_t fields_next;
    l4hx_pkg::result_t       result;

    // Register decode
    assign pready        = 1'b1;
    assign sel_link_type = (paddr[l4hx_pkg::PADDR_W-1:2] == l4hx_pkg::REG_LINK_TYPE);
    assign cfg_write     = psel && penable && pwrite && pready;
    assign prdata        = sel_link_type ? {30'd0, link_type_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= l4hx_pkg::LINK_ETHERNET;
        end
        else if (cfg_write && sel_link_type)
        begin
            link_type_reg <= pwdata[1:0];
        end
    end

    // Accept while the output register is free or being emptied
    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;
    assign load     = accept && last_byte && (link_type_reg != l4hx_pkg::LINK_NONE);

    l4hx_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .link_type   (link_type_reg),
        .fields_next (fields_next)
    );

    l4hx_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .link_type (link_type_reg),
        .fields    (fields_next),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    // Unpack the summary onto its ports
    assign status      = result.status;
    assign protocol    = result.protocol;
    assign ttl         = result.ttl;
    assign ip_length   = result.ip_length;
    assign src_addr    = result.src_addr;
    assign dst_addr    = result.dst_addr;
    assign source_port = result.source_port;
    assign dest_port   = result.dest_port;
    assign tcp_flags   = result.tcp_flags;
    assign seq_number  = result.seq_number;
    assign ack_number  = result.ack_number;
    assign window      = result.window;

endmodule
